// ===== rtl/lsfr_pkg.sv =====
// package: shared types and constants for the level sensor frame receiver
`default_nettype none

package lsfr_pkg;

    localparam int unsigned LevelW   = 16;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned TimeoutW = 16;
    localparam int unsigned StatusW  = 2;

    localparam logic [ByteW-1:0]    HEADER_BYTE   = 8'hFF;
    localparam logic [TimeoutW-1:0] ELAPSED_MAX   = 16'hFFFF;
    localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd10000;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [StatusW-1:0] {
        ST_NONE = 2'd0,
        ST_OK   = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/lsfr_ifs.sv =====
// interfaces: input item, result item and configuration write channels
`default_nettype none

interface lsfr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface lsfr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] level_mm;
    logic [1:0]  status;

    modport source (output valid, output level_mm, output status, input ready);
    modport sink   (input valid, input level_mm, input status, output ready);
endinterface

interface lsfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/level_sensor_frame_receiver.sv =====
// top level: level sensor frame receiver, byte window checker and timeout counter
// Each beat on i_in is a received byte or a one-millisecond tick and yields exactly one
// result beat on o_res carrying the held level in mm and the status (no sensor, success,
// checksum failure). An item passes an input register and then the result register; a new
// beat is taken every cycle except while i_in stalls, which happens only while both stages
// are full and o_res is held off. The timeout register is written through i_cfg, always
// ready, and resets to 10000 ms.
`default_nettype none

module level_sensor_frame_receiver (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lsfr_in_if.sink    i_in,
    lsfr_out_if.source o_res,
    lsfr_cfg_if.sink   i_cfg
);
    import lsfr_pkg::*;

    logic                r_in_vld;
    t_cmd                r_cmd;
    logic [ByteW-1:0]    r_byte;

    logic [3*ByteW-1:0]  r_win;
    logic [TimeoutW-1:0] r_elapsed;
    logic [LevelW-1:0]   r_level;
    t_status             r_status;
    logic [TimeoutW-1:0] r_timeout;

    logic                r_out_vld;
    logic [LevelW-1:0]   r_out_level;
    t_status             r_out_status;

    logic                adv;
    logic                is_byte;
    logic                hdr;
    logic                good;
    logic [ByteW-1:0]    sum;
    logic [3*ByteW-1:0]  n_win;
    logic [TimeoutW-1:0] n_elapsed;
    logic [LevelW-1:0]   n_level;
    t_status             n_status;

    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready  = !r_in_vld || adv;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid    = r_out_vld;
    assign o_res.level_mm = r_out_level;
    assign o_res.status   = r_out_status;

    // frame check on the window plus the new byte
    always_comb begin
        is_byte   = (r_cmd == CMD_BYTE);
        sum       = HEADER_BYTE + r_win[15:8] + r_win[7:0];
        hdr       = is_byte && (r_win[23:16] == HEADER_BYTE);
        good      = hdr && (sum == r_byte);
        n_win     = is_byte ? {r_win[15:0], r_byte} : r_win;
        n_level   = r_level;
        n_status  = r_status;
        n_elapsed = r_elapsed;
        if (good) begin
            n_level   = r_win[15:0];
            n_status  = ST_OK;
            n_elapsed = '0;
        end else if (hdr) begin
            n_status = ST_BAD;
        end else if (!is_byte && (r_elapsed != ELAPSED_MAX)) begin
            n_elapsed = r_elapsed + 1'b1;
        end
        if (n_elapsed > r_timeout) begin
            n_level  = '0;
            n_status = ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_win     <= '0;
            r_elapsed <= '0;
            r_level   <= '0;
            r_status  <= ST_NONE;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_win     <= n_win;
                r_elapsed <= n_elapsed;
                r_level   <= n_level;
                r_status  <= n_status;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd  <= t_cmd'(i_in.command);
            r_byte <= i_in.data_byte;
        end
        if (adv) begin
            r_out_level  <= n_level;
            r_out_status <= n_status;
        end
    end

    // no sensor always comes with a zero level
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == ST_NONE) |-> (r_level == '0))
        else $error("no sensor status with nonzero level");

    // a good frame restarts the elapsed counter
    a_good_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && good) |=> (r_elapsed == '0))
        else $error("elapsed not cleared after good frame");

    // input stalls only when both stages are full and output is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_vld && r_out_vld && !o_res.ready))
        else $error("input stalled without cause");

    // ticks leave the byte window alone
    a_tick_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_byte) |=> $stable(r_win))
        else $error("tick changed byte window");

endmodule

`default_nettype wire

// ===== sim/tb_level_sensor_frame_receiver.sv =====
// testbench: self-checking random and directed test of the level sensor frame receiver
`timescale 1ns / 1ps

module tb_level_sensor_frame_receiver;
    import lsfr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned PHASE_ITEMS    = 320;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] data;
    } t_rx_item;

    typedef struct {
        logic [LevelW-1:0] level;
        t_status           status;
    } t_reading;

    logic clk;
    logic rst_n;

    lsfr_in_if  in_bus ();
    lsfr_out_if res_bus ();
    lsfr_cfg_if cfg_bus ();

    level_sensor_frame_receiver i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus.sink),
        .o_res   (res_bus.source),
        .i_cfg   (cfg_bus.sink)
    );

    t_rx_item rx_queue[$];
    t_reading reading_queue[$];

    logic [23:0]         byte_window;
    logic [TimeoutW-1:0] elapsed_ms;
    logic [LevelW-1:0]   level_hold;
    t_status             status_hold;
    logic [TimeoutW-1:0] timeout_ms_now;

    int unsigned in_idle_pct;
    int unsigned out_stall_pct;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    logic        hold_arm;

    always #5 clk = ~clk;

    function automatic t_reading track_sensor(input t_cmd cmd, input logic [7:0] b);
        logic [7:0] head;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] sum;
        t_reading   r;
        if (cmd == CMD_BYTE) begin
            head = byte_window[23:16];
            hi   = byte_window[15:8];
            lo   = byte_window[7:0];
            byte_window = {byte_window[15:0], b};
            if (head == HEADER_BYTE) begin
                sum = HEADER_BYTE + hi + lo;
                if (sum == b) begin
                    level_hold  = {hi, lo};
                    status_hold = ST_OK;
                    elapsed_ms  = '0;
                end else begin
                    status_hold = ST_BAD;
                end
            end
        end else if (elapsed_ms != ELAPSED_MAX) begin
            elapsed_ms = elapsed_ms + 1'b1;
        end
        if (elapsed_ms > timeout_ms_now) begin
            level_hold  = '0;
            status_hold = ST_NONE;
        end
        r.level  = level_hold;
        r.status = status_hold;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // serial side: one beat per queued item
    always @(posedge clk) begin : serial_driver
        logic offer;
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            offer = in_bus.valid;
            if (in_bus.valid && in_bus.ready) begin
                reading_queue.push_back(track_sensor(t_cmd'(in_bus.command), in_bus.data_byte));
                rx_queue.delete(0);
                offer = 1'b0;
            end
            if (!offer && rx_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
                offer = 1'b1;
            if (offer) begin
                in_bus.command   <= rx_queue[0].cmd;
                in_bus.data_byte <= rx_queue[0].data;
            end
            in_bus.valid <= offer;
        end
    end

    always @(posedge clk) begin : reading_monitor
        t_reading want;
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (reading_queue.size() == 0) begin
                    report_mismatch("unexpected reading, level", res_bus.level_mm, '0);
                end else begin
                    want = reading_queue.pop_front();
                    if (res_bus.level_mm !== want.level)
                        report_mismatch("level_mm", res_bus.level_mm, want.level);
                    if (res_bus.status !== want.status)
                        report_mismatch("status", 16'(res_bus.status), 16'(want.status));
                end
            end
            res_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready)
                     || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        t_rx_item it;
        it.cmd  = CMD_BYTE;
        it.data = b;
        rx_queue.push_back(it);
    endtask

    task automatic push_ticks(input int unsigned n);
        t_rx_item it;
        it.cmd = CMD_TICK;
        repeat (n) begin
            it.data = 8'($urandom_range(0, 255));
            rx_queue.push_back(it);
        end
    endtask

    task automatic push_frame(input logic [7:0] hi, input logic [7:0] lo, input bit good);
        logic [7:0] cks;
        cks = HEADER_BYTE + hi + lo;
        if (!good)
            cks = cks ^ 8'($urandom_range(1, 255));
        push_byte(HEADER_BYTE);
        push_byte(hi);
        push_byte(lo);
        push_byte(cks);
    endtask

    task automatic queue_traffic(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        start = rx_queue.size();
        while (rx_queue.size() - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 62) begin
                push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 85) begin
                if ($urandom_range(0, 4) == 0)
                    push_ticks($urandom_range(30, 90));
                else
                    push_ticks($urandom_range(1, 24));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 3) == 0)
                        push_byte(HEADER_BYTE);
                    else
                        push_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic drain;
        while (rx_queue.size() != 0 || reading_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TimeoutW-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        timeout_ms_now = value;
    endtask

    task automatic set_idling(input int unsigned in_pct, input int unsigned out_pct);
        @(negedge clk);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
    endtask

    task automatic random_phase(input logic [TimeoutW-1:0] timeout_value,
                                input int unsigned in_pct, input int unsigned out_pct,
                                input bit with_hold);
        write_timeout(timeout_value);
        set_idling(in_pct, out_pct);
        if (with_hold) begin
            hold_arm = 1'b1;
            @(negedge clk);
            hold_arm = 1'b0;
        end
        queue_traffic(PHASE_ITEMS);
        drain();
    endtask

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.command   = CMD_BYTE;
        in_bus.data_byte = '0;
        res_bus.ready    = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = '0;
        hold_arm         = 1'b0;
        hold_left        = 0;
        in_idle_pct      = 0;
        out_stall_pct    = 0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        byte_window      = '0;
        elapsed_ms       = '0;
        level_hold       = '0;
        status_hold      = ST_NONE;
        timeout_ms_now   = TIMEOUT_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: start from reset, good and bad frames, extremes, overlap
        @(negedge clk);
        push_byte(8'h00);
        push_byte(8'hA5);
        push_frame(8'h12, 8'h34, 1'b1);
        push_frame(8'h00, 8'h00, 1'b0);
        push_frame(8'hFF, 8'hFF, 1'b1);
        push_frame(8'h00, 8'h00, 1'b1);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h02);
        push_ticks(3);
        // ticks under the reset timeout
        push_ticks(20);
        drain();

        // zero timeout
        write_timeout(16'd0);
        @(negedge clk);
        push_frame(8'h80, 8'h01, 1'b1);
        push_ticks(1);
        push_byte(8'h7F);
        drain();

        // largest timeout, then one below it
        write_timeout(16'hFFFF);
        @(negedge clk);
        push_frame(8'h55, 8'hAA, 1'b1);
        push_ticks(40);
        drain();
        write_timeout(16'd65534);
        @(negedge clk);
        push_ticks(1);
        push_frame(8'h3C, 8'hC3, 1'b1);
        push_ticks(2);
        drain();

        random_phase(16'd20, 0, 0, 1'b0);
        random_phase(16'($urandom_range(1, 60)), 88, 0, 1'b0);
        random_phase(16'd3, 0, 88, 1'b0);
        random_phase(16'($urandom_range(0, 40)), 10, 10, 1'b0);
        random_phase(16'd0, 0, 0, 1'b1);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lsfr_pkg.sv
rtl/lsfr_ifs.sv
rtl/level_sensor_frame_receiver.sv
sim/tb_level_sensor_frame_receiver.sv
